// ----- rtl/sfmp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmp_pkg: shared types for the symbolic file mode parser
// parse phase and operator codes plus the parse state record
// ----------------------------------------------------------------------------
package sfmp_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned ModeW = 16;
	localparam int unsigned PermW = 12;
	localparam int unsigned ClassW = 3;

	typedef enum logic [1:0] {
		PH_WHO  = 2'd0,
		PH_PERM = 2'd1,
		PH_ERR  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_SET = 2'd2
	} op_kind_t;

	typedef struct packed {
		phase_t              phase;
		logic [ClassW-1:0]   class_set;
		op_kind_t            op_kind;
		logic [PermW-1:0]    pending_bits;
		logic                saw_perm;
	} parse_state_t;

	localparam parse_state_t ParseIdle = '{
		phase:        PH_WHO,
		class_set:    '0,
		op_kind:      OP_ADD,
		pending_bits: '0,
		saw_perm:     1'b0
	};

endpackage

// ----- rtl/sfmp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmp_if: channel interfaces of the symbolic file mode parser
// character input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sfmp_char_if;
	logic        valid;
	logic        ready;
	logic [7:0]  ch;
	logic        first;
	logic        last;
	logic [15:0] init_mode;

	modport source (output valid, output ch, output first, output last,
		output init_mode, input ready);
	modport sink (input valid, input ch, input first, input last,
		input init_mode, output ready);
endinterface

interface sfmp_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] new_mode;
	logic        bad_syntax;

	modport source (output valid, output new_mode, output bad_syntax, input ready);
	modport sink (input valid, input new_mode, input bad_syntax, output ready);
endinterface

// ----- rtl/symbolic_file_mode_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbolic_file_mode_parser_top: symbolic chmod-style mode parser
// applies a stream of clause characters to a 16-bit file mode
// ----------------------------------------------------------------------------
// usage
//   chars  : one character per transaction; first loads init_mode and
//            restarts the parse, last closes the string
//   result : one transaction per string, new_mode and bad_syntax, given for
//            the character that carries last
// latency and throughput
//   one character per cycle unless a stalled result holds input; the result is
//   valid the cycle after the last character is taken; the pace is set by the
//   single decode step between the parse state registers and the result register
// stall
//   the result register holds while the sink stalls; chars.ready stays high
//   as long as the result register is empty or being drained this cycle, so
//   a stalled result holds back every character until it is taken
// reset
//   arst_n clears the parse state, the mode accumulator, the held start mode
//   and the result valid flag; a string sent without first after reset starts
//   from a mode of zero
// ----------------------------------------------------------------------------
module symbolic_file_mode_parser_top (
	input  logic                 clk,
	input  logic                 arst_n,
	sfmp_char_if.sink            chars,
	sfmp_result_if.source        result
);
	import sfmp_pkg::*;

	// parse state and mode accumulator
	parse_state_t     state_q;
	logic [ModeW-1:0] acc_q;
	logic [ModeW-1:0] hold_q;

	// result register
	logic             res_valid_q;
	logic [ModeW-1:0] res_mode_q;
	logic             res_bad_q;

	// next-state from the step logic
	parse_state_t     state_nxt;
	logic [ModeW-1:0] acc_nxt;
	logic [ModeW-1:0] hold_nxt;
	logic [ModeW-1:0] step_mode;
	logic             step_bad;
	logic             in_fire;

	// take a character unless a finished result is still waiting
	assign chars.ready = !res_valid_q || result.ready;
	assign in_fire     = chars.valid && chars.ready;

	sfmp_step u_step (
		.cur        (state_q),
		.mode_acc   (acc_q),
		.start_hold (hold_q),
		.ch         (chars.ch),
		.first      (chars.first),
		.last       (chars.last),
		.init_mode  (chars.init_mode),
		.nxt        (state_nxt),
		.nxt_acc    (acc_nxt),
		.nxt_hold   (hold_nxt),
		.res_mode   (step_mode),
		.res_bad    (step_bad)
	);

	// parse state advances on every accepted character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ParseIdle;
			acc_q   <= '0;
			hold_q  <= '0;
		end else if (in_fire) begin
			state_q <= state_nxt;
			acc_q   <= acc_nxt;
			hold_q  <= hold_nxt;
		end
	end

	// result valid flag: set by a last character, cleared when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_fire && chars.last) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, loaded only when a string closes
	always_ff @(posedge clk) begin
		if (in_fire && chars.last) begin
			res_mode_q <= step_mode;
			res_bad_q  <= step_bad;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.new_mode   = res_mode_q;
	assign result.bad_syntax = res_bad_q;

endmodule

// ----- rtl/sfmp_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmp_step: next-state logic for one character
// decodes one character against the parse state and mode accumulator
// ----------------------------------------------------------------------------
module sfmp_step (
	input  sfmp_pkg::parse_state_t cur,
	input  logic [15:0]            mode_acc,
	input  logic [15:0]            start_hold,
	input  logic [7:0]             ch,
	input  logic                   first,
	input  logic                   last,
	input  logic [15:0]            init_mode,
	output sfmp_pkg::parse_state_t nxt,
	output logic [15:0]            nxt_acc,
	output logic [15:0]            nxt_hold,
	output logic [15:0]            res_mode,
	output logic                   res_bad
);
	import sfmp_pkg::*;

	localparam logic [CharW-1:0] ChU     = 8'h75; // u
	localparam logic [CharW-1:0] ChG     = 8'h67; // g
	localparam logic [CharW-1:0] ChO     = 8'h6F; // o
	localparam logic [CharW-1:0] ChA     = 8'h61; // a
	localparam logic [CharW-1:0] ChPlus  = 8'h2B; // +
	localparam logic [CharW-1:0] ChMinus = 8'h2D; // -
	localparam logic [CharW-1:0] ChEq    = 8'h3D; // =
	localparam logic [CharW-1:0] ChComma = 8'h2C; // ,
	localparam logic [CharW-1:0] ChR     = 8'h72; // r
	localparam logic [CharW-1:0] ChW     = 8'h77; // w
	localparam logic [CharW-1:0] ChX     = 8'h78; // x
	localparam logic [CharW-1:0] ChXcap  = 8'h58; // X
	localparam logic [CharW-1:0] ChS     = 8'h73; // s
	localparam logic [CharW-1:0] ChT     = 8'h74; // t

	// replicate a 3-bit rwx value into the selected classes
	function automatic logic [PermW-1:0] spread(logic [ClassW-1:0] who, logic [2:0] v);
		return {3'b000, who[0] ? v : 3'b000, who[1] ? v : 3'b000, who[2] ? v : 3'b000};
	endfunction

	function automatic logic [PermW-1:0] perm_mask(logic [ClassW-1:0] who,
		logic [CharW-1:0] c, logic [ModeW-1:0] base);
		logic x_ok;
		logic [PermW-1:0] m;
		x_ok = (base[15:12] == 4'b0100) || (base[6] | base[3] | base[0]);
		case (c)
			ChR:     m = spread(who, 3'b100);
			ChW:     m = spread(who, 3'b010);
			ChX:     m = spread(who, 3'b001);
			ChXcap:  m = x_ok ? spread(who, 3'b001) : '0;
			ChS:     m = {who[0], who[1], 10'b0};
			ChT:     m = {2'b00, who[2], 9'b0};
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [ModeW-1:0] apply_clause(logic [ModeW-1:0] acc,
		parse_state_t st);
		logic [ModeW-1:0] p;
		logic [ModeW-1:0] clr;
		logic [ModeW-1:0] r;
		p   = {4'b0000, st.pending_bits};
		// rwx of each chosen class plus its setuid, setgid or sticky bit
		clr = {4'b0000, st.class_set[0], st.class_set[1], st.class_set[2], 9'b0} |
			{4'b0000, spread(st.class_set, 3'b111)};
		case (st.op_kind)
			OP_ADD:  r = acc | p;
			OP_SUB:  r = acc & ~p;
			OP_SET:  r = (acc & ~clr) | p;
			default: r = acc;
		endcase
		return r;
	endfunction

	parse_state_t     st0;
	parse_state_t     st1;
	logic [ModeW-1:0] acc0;
	logic [ModeW-1:0] acc1;
	logic [ModeW-1:0] hold0;
	logic             clause_ok;
	logic             end_ok;

	always_comb begin
		// a first character restarts the parse from the new starting mode
		st0   = first ? ParseIdle : cur;
		acc0  = first ? init_mode : mode_acc;
		hold0 = first ? init_mode : start_hold;
		st1   = st0;
		acc1  = acc0;
		clause_ok = st0.saw_perm || (st0.op_kind == OP_SET);

		case (st0.phase)
			PH_WHO: begin
				case (ch)
					ChU, ChG, ChO, ChA: begin
						st1.class_set = st0.class_set | {
							(ch == ChO) || (ch == ChA),
							(ch == ChG) || (ch == ChA),
							(ch == ChU) || (ch == ChA)};
					end
					ChPlus, ChMinus, ChEq: begin
						st1.op_kind = (ch == ChPlus) ? OP_ADD :
							(ch == ChMinus) ? OP_SUB : OP_SET;
						if (st0.class_set == '0) begin
							st1.class_set = '1;
						end
						st1.pending_bits = '0;
						st1.saw_perm     = 1'b0;
						st1.phase        = PH_PERM;
					end
					default: st1.phase = PH_ERR;
				endcase
			end
			PH_PERM: begin
				case (ch)
					ChR, ChW, ChX, ChXcap, ChS, ChT: begin
						st1.pending_bits = st0.pending_bits |
							perm_mask(st0.class_set, ch, acc0);
						st1.saw_perm = 1'b1;
					end
					ChComma: begin
						if (clause_ok) begin
							acc1             = apply_clause(acc0, st0);
							st1.phase        = PH_WHO;
							st1.class_set    = '0;
							st1.pending_bits = '0;
							st1.saw_perm     = 1'b0;
						end else begin
							st1.phase = PH_ERR;
						end
					end
					default: st1.phase = PH_ERR;
				endcase
			end
			default: st1.phase = PH_ERR;
		endcase

		// end of string closes the open clause
		end_ok   = (st1.phase == PH_PERM) &&
			(st1.saw_perm || (st1.op_kind == OP_SET));
		res_bad  = !end_ok;
		res_mode = end_ok ? apply_clause(acc1, st1) : hold0;

		if (last) begin
			nxt      = ParseIdle;
			nxt_acc  = res_mode;
			nxt_hold = res_mode;
		end else begin
			nxt      = st1;
			nxt_acc  = acc1;
			nxt_hold = hold0;
		end
	end

endmodule

// ----- rtl/sfmp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmp_checker: port-level checks for the symbolic file mode parser
// watches both channels of the top level through a bind
// ----------------------------------------------------------------------------
module sfmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_mode,
	input logic        out_bad
);

	// a closing character always yields a result next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> out_valid)
		else $error("no result after last character");

	// a result only appears after a closing character
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last))
		else $error("result without a closing character");

	// an empty result stage never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result stage");

	// a stalled result blocks input so it cannot be overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while result stalled");

	// stalled result holds its payload
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_mode) && $stable(out_bad)))
		else $error("stalled result changed");

endmodule

bind symbolic_file_mode_parser_top sfmp_checker u_sfmp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_last   (chars.last),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_mode  (result.new_mode),
	.out_bad   (result.bad_syntax)
);
